/* sv/swbm_pkg.sv */
package swbm_pkg;

  localparam int TIME_W   = 32;
  localparam int BYTES_W  = 16;
  localparam int BUCKET_W = 32;
  localparam int TOTAL_W  = 36;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX = {BUCKET_W{1'b1}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* sv/sliding_window_byte_meter_unit.sv */
// Sliding-window byte meter.
// Input channel (in_valid/in_ready): present time in whole seconds and a byte
// count for that second. Result channel (out_valid/out_ready): one window
// total per input transaction, the saturated sum of all per-second buckets.
// The buckets live in a ring of BUCKETS cells; cell 0 is always the current
// second. Each elapsed second rotates the ring by one cell and empties the
// slot entered, one cell per cycle, at most BUCKETS times per transaction.
// A transaction steps through ST_ADV for each elapsed second (the gap to the
// previous time), up to BUCKETS, then ST_ADD writes the total back and sets
// out_valid; a time that goes backward skips ST_ADV and adds nothing. One
// transaction is processed at a time: a new one is taken only once the last
// is written back. The result register holds a finished total while the
// receiver stalls; a following transaction is taken and rotated in the
// meantime and waits only for the final write-back. Reset (rst_n low, sync)
// empties every bucket and clears the total, the last time and out_valid.
module sliding_window_byte_meter_unit #(
  parameter int BUCKETS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swbm_pkg::TIME_W-1:0]  in_current_second,
  input  logic [swbm_pkg::BYTES_W-1:0] in_byte_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swbm_pkg::TOTAL_W-1:0] out_window_total
);

  localparam int CW = $clog2(BUCKETS + 1);
  localparam int TW = swbm_pkg::BUCKET_W + $clog2(BUCKETS);
  localparam int EW = (TW > swbm_pkg::TOTAL_W) ? TW : swbm_pkg::TOTAL_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ADV, ST_ADD} state_t;

  state_t                         state_r;
  logic [CW-1:0]                  cnt_r;
  logic [swbm_pkg::BYTES_W-1:0]   bytes_r;
  logic                           drop_r;
  logic [swbm_pkg::TIME_W-1:0]    last_r;
  logic [TW-1:0]                  tot_r;
  logic                           out_valid_r;
  logic [swbm_pkg::TOTAL_W-1:0]   out_total_r;

  logic [swbm_pkg::BUCKET_W-1:0]  cell_val [BUCKETS];
  logic [swbm_pkg::BUCKET_W-1:0]  nbr_val  [BUCKETS];
  swbm_pkg::cell_ctrl_t           ctrl     [BUCKETS];

  logic                           in_fire;
  logic                           out_free;
  logic                           commit;
  logic [swbm_pkg::TIME_W-1:0]    gap;
  logic [swbm_pkg::BUCKET_W:0]    add_sum;
  logic [swbm_pkg::BUCKET_W-1:0]  add_val;
  logic [TW-1:0]                  tot_add;
  logic [TW-1:0]                  tot_fin;
  logic [EW-1:0]                  tot_ext;
  logic [swbm_pkg::TOTAL_W-1:0]   tot_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_ADD) && out_free;
  assign gap      = in_current_second - last_r;

  assign add_sum = {1'b0, cell_val[0]} + (swbm_pkg::BUCKET_W + 1)'(bytes_r);
  assign add_val = add_sum[swbm_pkg::BUCKET_W] ? swbm_pkg::BUCKET_MAX
                                                : add_sum[swbm_pkg::BUCKET_W-1:0];
  assign tot_add = tot_r + TW'(add_val) - TW'(cell_val[0]);
  assign tot_fin = drop_r ? tot_r : tot_add;
  assign tot_ext = EW'(tot_fin);
  assign tot_sat = (tot_ext > EW'(swbm_pkg::TOTAL_MAX)) ? swbm_pkg::TOTAL_MAX
                                                         : tot_ext[swbm_pkg::TOTAL_W-1:0];

  genvar k;
  generate
    for (k = 0; k < BUCKETS; k++) begin : g_cell
      if (k == BUCKETS - 1) begin : g_wrap
        assign nbr_val[k] = cell_val[0];
      end else begin : g_next
        assign nbr_val[k] = cell_val[k+1];
      end
      assign ctrl[k].shift = (state_r == ST_ADV);
      assign ctrl[k].load  = (k == 0) && commit && !drop_r;
      swbm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl[k]),
        .nbr_val  ((k == 0) ? '0 : nbr_val[k]),
        .load_val (add_val),
        .value    (cell_val[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bytes_r     <= '0;
      drop_r      <= 1'b0;
      last_r      <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
      out_total_r <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            bytes_r <= in_byte_count;
            last_r  <= in_current_second;
            if (in_current_second < last_r) begin
              drop_r  <= 1'b1;
              state_r <= ST_ADD;
            end else begin
              drop_r <= 1'b0;
              if (gap == '0) begin
                state_r <= ST_ADD;
              end else begin
                cnt_r   <= (gap >= swbm_pkg::TIME_W'(BUCKETS)) ? CW'(BUCKETS)
                                                               : gap[CW-1:0];
                state_r <= ST_ADV;
              end
            end
          end
        end
        ST_ADV: begin
          tot_r <= tot_r - TW'(nbr_val[0]);
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (out_free) begin
            tot_r       <= tot_fin;
            out_total_r <= tot_sat;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_total = out_total_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(BUCKETS))
    else $error("advance count beyond bucket count");

  a_adv_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADV |=> cell_val[0] == '0)
    else $error("entered slot not emptied");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("transaction accepted without processing");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("result lost at write-back");

endmodule

/* sv/swbm_cell.sv */
module swbm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swbm_pkg::cell_ctrl_t          ctrl,
  input  logic [swbm_pkg::BUCKET_W-1:0] nbr_val,
  input  logic [swbm_pkg::BUCKET_W-1:0] load_val,
  output logic [swbm_pkg::BUCKET_W-1:0] value
);

  logic [swbm_pkg::BUCKET_W-1:0] value_r;
  logic [swbm_pkg::BUCKET_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.load) begin
      value_nxt = load_val;
    end else if (ctrl.shift) begin
      value_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

/* dv/sliding_window_byte_meter_checker.sv */
`timescale 1ns / 100ps

module sliding_window_byte_meter_checker #(
  parameter int BUCKETS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [swbm_pkg::TIME_W-1:0]   in_current_second,
  input  logic [swbm_pkg::BYTES_W-1:0]  in_byte_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swbm_pkg::TOTAL_W-1:0]  out_window_total,
  output int unsigned                   fail_count,
  output int unsigned                   pending,
  output int unsigned                   checked
);

  logic [swbm_pkg::BUCKET_W-1:0] bucket_q [BUCKETS];
  int unsigned                   slot_q;
  logic [swbm_pkg::TIME_W-1:0]   last_sec_q;
  logic [swbm_pkg::TOTAL_W-1:0]  total_q;
  logic [swbm_pkg::TOTAL_W-1:0]  totals_due [$];

  task automatic flag_mismatch(input string what);
    if (fail_count < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic logic [swbm_pkg::TOTAL_W-1:0] meter_update(
    input logic [swbm_pkg::TIME_W-1:0]  now,
    input logic [swbm_pkg::BYTES_W-1:0] bytes
  );
    logic [swbm_pkg::TIME_W-1:0]   gap;
    logic [swbm_pkg::BUCKET_W:0]   slot_sum;
    logic [swbm_pkg::TOTAL_W:0]    sum;
    if (now >= last_sec_q) begin
      gap = now - last_sec_q;
      if (gap > BUCKETS) begin
        gap = BUCKETS;
      end
      for (int unsigned i = 0; i < gap; i++) begin
        slot_q = (slot_q + 1) % BUCKETS;
        bucket_q[slot_q] = '0;
      end
      slot_sum = {1'b0, bucket_q[slot_q]} + bytes;
      if (slot_sum > swbm_pkg::BUCKET_MAX) begin
        slot_sum = swbm_pkg::BUCKET_MAX;
      end
      bucket_q[slot_q] = slot_sum[swbm_pkg::BUCKET_W-1:0];
      sum = '0;
      for (int unsigned i = 0; i < BUCKETS; i++) begin
        sum = sum + bucket_q[i];
        if (sum > swbm_pkg::TOTAL_MAX) begin
          sum = swbm_pkg::TOTAL_MAX;
        end
      end
      total_q = sum[swbm_pkg::TOTAL_W-1:0];
    end
    last_sec_q = now;
    return total_q;
  endfunction

  always @(posedge clk) begin
    logic [swbm_pkg::TOTAL_W-1:0] due;
    if (!rst_n) begin
      foreach (bucket_q[i]) bucket_q[i] = '0;
      slot_q = 0;
      last_sec_q = '0;
      total_q = '0;
      totals_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          flag_mismatch($sformatf("window total %0h with no transaction outstanding",
                                  out_window_total));
        end else begin
          due = totals_due.pop_front();
          if (out_window_total !== due) begin
            flag_mismatch($sformatf("window total %0h, expected %0h", out_window_total, due));
          end
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        totals_due.push_back(meter_update(in_current_second, in_byte_count));
      end
    end
    pending <= totals_due.size();
  end

endmodule

/* dv/sliding_window_byte_meter_unit_tb.sv */
`timescale 1ns / 100ps

module sliding_window_byte_meter_unit_tb;

  localparam int          BUCKETS      = 16;
  localparam int unsigned FILL_ITEMS   = 40;
  localparam int unsigned RANDOM_ITEMS = 940;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [swbm_pkg::TIME_W-1:0]   in_current_second = '0;
  logic [swbm_pkg::BYTES_W-1:0]  in_byte_count = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [swbm_pkg::TOTAL_W-1:0]  out_window_total;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned burst_left;
  int unsigned sent;
  int unsigned ready_run;
  int unsigned idle_cycles;
  int unsigned n_backward;
  int unsigned n_long;

  sliding_window_byte_meter_unit #(
    .BUCKETS(BUCKETS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_current_second (in_current_second),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_window_total  (out_window_total)
  );

  sliding_window_byte_meter_checker #(
    .BUCKETS(BUCKETS)
  ) chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_current_second (in_current_second),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_window_total  (out_window_total),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
      ready_run <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_reading(input logic [swbm_pkg::TIME_W-1:0] t,
                              input logic [swbm_pkg::BYTES_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 22);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_current_second <= t;
    in_byte_count <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  initial begin
    logic [swbm_pkg::TIME_W-1:0]  now_t;
    logic [swbm_pkg::TIME_W-1:0]  step_t;
    logic [swbm_pkg::BYTES_W-1:0] amount;
    int unsigned                  pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_reading(32'd0, 16'h0000);
    send_reading(32'd0, 16'hFFFF);
    send_reading(32'd1, 16'h0001);
    send_reading(32'd1, 16'hFFFF);
    send_reading(32'd0, 16'h0007);
    send_reading(32'd0, 16'h0000);
    send_reading(32'd3, 16'h8000);
    send_reading(32'd19, 16'h00FF);
    send_reading(32'd36, 16'h0001);
    send_reading(32'd37, 16'h0002);
    send_reading(32'd52, 16'h0003);
    send_reading(32'hFFFF_FFFF, 16'hFFFF);
    send_reading(32'hFFFF_FFFF, 16'h5555);
    send_reading(32'd0, 16'hAAAA);
    send_reading(32'h8000_0000, 16'h7FFF);
    send_reading(32'h7FFF_FFFF, 16'h1234);
    send_reading(32'h7FFF_FFFF, 16'h0000);
    send_reading(32'h8000_0000, 16'h0009);
    send_reading(32'hAAAA_AAAA, 16'hFFFF);
    send_reading(32'h5555_5555, 16'h0001);
    send_reading(32'h5555_5556, 16'h0002);

    // pile full byte counts into one second
    now_t = 32'h5555_5557;
    for (int unsigned n = 0; n < FILL_ITEMS; n++) begin
      send_reading(now_t, 16'hFFFF);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        step_t = now_t;
      end else if (pick < 75) begin
        step_t = now_t + $urandom_range(1, 3);
      end else if (pick < 87) begin
        step_t = now_t + $urandom_range(4, 40);
      end else if (pick < 94) begin
        step_t = now_t - $urandom_range(1, 20);
      end else begin
        step_t = $urandom();
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        amount = '0;
      end else if (pick == 1) begin
        amount = '1;
      end else begin
        amount = $urandom_range(0, 65535);
      end
      if (step_t < now_t) begin
        n_backward++;
      end else if (step_t - now_t >= BUCKETS) begin
        n_long++;
      end
      send_reading(step_t, amount);
      now_t = step_t;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * BUCKETS + 8) @(posedge clk);

    $display("Sent %0d readings (%0d full counts into one second), checked %0d window totals",
             sent, FILL_ITEMS, checked);
    $display("Random part: %0d backward steps, %0d gaps of a full window or more",
             n_backward, n_long);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
